/* design/ldr_pkg.sv */
// ldr_pkg: shared types and character codes for the line directive recognizer
// used by ldr_parse and line_directive_recognizer_top; no dependencies
package ldr_pkg;

  localparam int LineNumW = 31;
  localparam int OutPosW  = 32;

  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [2:0] KW_LEN = 3'd4;

  // one result item, output fields at their fixed widths
  typedef struct packed {
    logic                 directive_found;
    logic [LineNumW-1:0]  line_number;
    logic [OutPosW-1:0]   name_open_pos;
    logic [OutPosW-1:0]   name_close_pos;
    logic [OutPosW-1:0]   newline_pos;
  } ldr_result_t;

  // characters of the keyword "line"
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h6C;
      2'd1:    ch = 8'h69;
      2'd2:    ch = 8'h6E;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

endpackage

/* design/line_directive_recognizer_top.sv */
// line_directive_recognizer_top: byte stream in, one result per newline out
// uses ldr_parse for the per-byte state machine and ldr_pkg for types
//
// channel | dir | tdata                         | tuser            | tlast
// in_*    | in  | [7:0] text_byte               | -                | final_byte
// out_*   | out | line_number, open, close, nl  | directive_found  | -
//
// one byte per cycle; the result of a newline byte is registered in the
// output register, or in the skid entry while the output is held. an output
// register plus one skid entry let input keep flowing while a result waits;
// in_tready drops only when both are full. rst_n (sync, active low) clears
// parse state and the byte counter; the final byte of a text clears them as well.
module line_directive_recognizer_top #(
  parameter int POSITION_BITS = 32,
  parameter int NUMBER_BITS   = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] text_byte
  input  logic         in_tlast,   // final_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [30:0] line_number, [62:31] name_open_pos, [94:63] name_close_pos,
  // [126:95] newline_pos, [127] zero
  output logic [127:0] out_tdata,
  output logic         out_tuser   // directive_found
);
  import ldr_pkg::*;

  logic        in_fire, pop, res_valid;
  ldr_result_t res;
  ldr_result_t out_r, skid_r;
  logic        out_vld_r, skid_vld_r;

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign pop       = out_vld_r && out_tready;

  ldr_parse #(
    .POSITION_BITS(POSITION_BITS),
    .NUMBER_BITS  (NUMBER_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .text_byte (in_tdata),
    .final_byte(in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || pop) begin
      out_vld_r <= res_valid;
    end else if (res_valid) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (!out_vld_r || pop) begin
      if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.directive_found;
  assign out_tdata  = {1'b0, out_r.newline_pos, out_r.name_close_pos,
                       out_r.name_open_pos, out_r.line_number};

endmodule

/* design/ldr_parse.sv */
// ldr_parse: per-byte line marker state machine, one byte per transfer
// produces a result at each newline; depends on ldr_pkg
module ldr_parse #(
  parameter int POSITION_BITS = 32,
  parameter int NUMBER_BITS   = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_fire,
  input  logic [7:0]           text_byte,
  input  logic                 final_byte,
  output logic                 res_valid,
  output ldr_pkg::ldr_result_t res
);
  import ldr_pkg::*;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_KEYWORD = 3'd1;
  localparam logic [2:0] PH_GAP     = 3'd2;
  localparam logic [2:0] PH_DIGITS  = 3'd3;
  localparam logic [2:0] PH_PAD     = 3'd4;
  localparam logic [2:0] PH_NAME    = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  localparam logic [NUMBER_BITS-1:0] NumMax = '1;

  logic [2:0]               phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r;
  logic [2:0]               kw_idx_r, kw_idx_nxt;
  logic [NUMBER_BITS-1:0]   accum_r, accum_nxt;
  logic [POSITION_BITS-1:0] open_pos_r, open_pos_nxt;
  logic [POSITION_BITS-1:0] last_pos_r, last_pos_nxt;
  logic                     qafter_r, qafter_nxt;

  logic                     is_blank, is_digit, is_quote, is_nl;
  logic [3:0]               digit;
  logic [NUMBER_BITS+3:0]   accum_x10;
  logic                     found;

  logic [NUMBER_BITS+LineNumW-1:0]  num_ext;
  logic [POSITION_BITS+OutPosW-1:0] open_ext, last_ext, nl_ext;

  assign is_blank = (text_byte == CHR_SPACE) || (text_byte == CHR_TAB);
  assign is_digit = (text_byte >= CHR_ZERO) && (text_byte <= CHR_NINE);
  assign is_quote = (text_byte == CHR_QUOTE);
  assign is_nl    = (text_byte == CHR_NL);
  assign digit    = text_byte[3:0];

  // accum * 10 + digit, saturating when it passes the all-ones maximum
  assign accum_x10 = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1)
                   + {{NUMBER_BITS{1'b0}}, digit};

  always_comb begin
    phase_nxt    = phase_r;
    kw_idx_nxt   = kw_idx_r;
    accum_nxt    = accum_r;
    open_pos_nxt = open_pos_r;
    last_pos_nxt = last_pos_r;
    qafter_nxt   = qafter_r;
    if (is_nl) begin
      phase_nxt  = PH_START;
      kw_idx_nxt = '0;
      qafter_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_START: begin
          if (text_byte == CHR_HASH) begin
            phase_nxt  = PH_KEYWORD;
            kw_idx_nxt = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_KEYWORD: begin
          if (is_blank) begin
            phase_nxt = (kw_idx_r == '0 || kw_idx_r == KW_LEN) ? PH_GAP : PH_SKIP;
          end else if (kw_idx_r < KW_LEN && text_byte == kw_char(kw_idx_r[1:0])) begin
            kw_idx_nxt = kw_idx_r + 3'd1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_GAP: begin
          if (is_digit) begin
            accum_nxt = {{(NUMBER_BITS-4){1'b0}}, digit};
            phase_nxt = PH_DIGITS;
          end else if (!is_blank) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            accum_nxt = (accum_x10 > {4'b0, NumMax}) ? NumMax
                                                     : accum_x10[NUMBER_BITS-1:0];
          end else if (is_blank) begin
            phase_nxt = PH_PAD;
          end else if (is_quote) begin
            open_pos_nxt = pos_r;
            qafter_nxt   = 1'b0;
            phase_nxt    = PH_NAME;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_PAD: begin
          if (is_quote) begin
            open_pos_nxt = pos_r;
            qafter_nxt   = 1'b0;
            phase_nxt    = PH_NAME;
          end else if (!is_blank) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_NAME: begin
          if (is_quote) begin
            last_pos_nxt = pos_r;
            qafter_nxt   = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // control state clears on reset and after the final byte of a text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      pos_r    <= '0;
      kw_idx_r <= '0;
      qafter_r <= 1'b0;
    end else if (byte_fire) begin
      if (final_byte) begin
        phase_r  <= PH_START;
        pos_r    <= '0;
        kw_idx_r <= '0;
        qafter_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_r + 1'b1;
        kw_idx_r <= kw_idx_nxt;
        qafter_r <= qafter_nxt;
      end
    end
  end

  // payload: only read after the phase walk has written it
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      accum_r    <= accum_nxt;
      open_pos_r <= open_pos_nxt;
      last_pos_r <= last_pos_nxt;
    end
  end

  assign found    = (phase_r == PH_NAME) && qafter_r;
  assign num_ext  = {{LineNumW{1'b0}}, accum_r};
  assign open_ext = {{OutPosW{1'b0}}, open_pos_r};
  assign last_ext = {{OutPosW{1'b0}}, last_pos_r};
  assign nl_ext   = {{OutPosW{1'b0}}, pos_r};

  assign res_valid           = byte_fire && is_nl;
  assign res.directive_found = found;
  assign res.line_number     = found ? num_ext[LineNumW-1:0] : '0;
  assign res.name_open_pos   = found ? open_ext[OutPosW-1:0] : '0;
  assign res.name_close_pos  = found ? last_ext[OutPosW-1:0] : '0;
  assign res.newline_pos     = nl_ext[OutPosW-1:0];

endmodule
